>>> rtl/core/bbs_pkg.sv
// Package for the 3x3 box blur stream: sizes, codes and the shared types
// that travel between its modules. No dependencies.
`default_nettype none

package bbs_pkg;

    // Default size limits handed to the top level parameters
    localparam int MAX_WIDTH_DEF  = 2048;
    localparam int MAX_HEIGHT_DEF = 2048;

    // Configuration registers
    localparam int CFG_W      = 12;
    localparam int CFG_AW     = 3;
    localparam int APB_DW     = 32;
    localparam int WIDTH_RST  = 640;
    localparam int HEIGHT_RST = 480;
    localparam int MIN_DIM    = 3;

    typedef enum logic
    {
        REG_WIDTH  = 1'b0,
        REG_HEIGHT = 1'b1
    } cfg_reg_t;

    // Payload widths
    localparam int PIX_W   = 8;
    localparam int COORD_W = 11;

    // Window sum and divide by nine: floor(s / 9) == (s * 3641) >> 15 for s < 32768
    localparam int          SUM_W      = 12;
    localparam int          PROD_W     = 2 * SUM_W;
    localparam logic [11:0] DIV9_MUL   = 12'd3641;
    localparam int          DIV9_SHIFT = 15;

    // Result queue
    localparam int OUT_DEPTH = 8;
    localparam int OUT_AW    = 3;
    localparam int OUT_CW    = 4;

    // 3x3 window, index row*3+col, row 0 oldest, col 2 newest
    typedef logic [8:0][PIX_W-1:0] win_t;

    // Coordinates carried alongside a pixel
    typedef struct packed
    {
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic               last;
    } meta_t;

    // Line store pipeline status
    typedef struct packed
    {
        logic v1;   // item in the memory read stage
        logic e1;   // that item produces a result
        logic v2;   // window holds a result item
    } ls_stat_t;

    // One result item
    typedef struct packed
    {
        logic [PIX_W-1:0]   pixel;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic               last;
    } res_t;

endpackage

`default_nettype wire

>>> rtl/core/bbs_if.sv
// Stream interfaces of the box blur: pixel input channel and result channel.
// Depends on bbs_pkg for payload widths.
`default_nettype none

interface bbs_pix_if;
    import bbs_pkg::*;

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_in;

    modport source (output valid, output pixel_in, input ready);
    modport sink   (input valid, input pixel_in, output ready);
endinterface

interface bbs_res_if;
    import bbs_pkg::*;

    logic               valid;
    logic               ready;
    logic [PIX_W-1:0]   pixel_out;
    logic [COORD_W-1:0] out_row;
    logic [COORD_W-1:0] out_col;
    logic               frame_last;

    modport source (output valid, output pixel_out, output out_row, output out_col,
                    output frame_last, input ready);
    modport sink   (input valid, input pixel_out, input out_row, input out_col,
                    input frame_last, output ready);
endinterface

`default_nettype wire

>>> rtl/core/box_blur_3x3_stream.sv
// 3x3 box blur on a raster pixel stream.
// The completing pixel passes the memory read stage, window register, registered sum and result queue.
// Throughput: one pixel per cycle while the queue has room, set by the line store's one read and one write a cycle.
// Output stalls are absorbed by an 8-entry result queue; input backs off when it could fill.
// Reset: counters, window and queue clear, size registers go to 640x480; line stores keep data.
// Depends on bbs_pkg, bbs_if, bbs_cfg_regs, bbs_line_store, bbs_mean, bbs_out_fifo.
`default_nettype none

module box_blur_3x3_stream #(
    parameter int MAX_WIDTH  = bbs_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = bbs_pkg::MAX_HEIGHT_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    bbs_pix_if.sink                          pixels,
    bbs_res_if.source                        results,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [bbs_pkg::CFG_AW-1:0]  paddr,
    input  wire logic [bbs_pkg::APB_DW-1:0]  pwdata,
    output logic      [bbs_pkg::APB_DW-1:0]  prdata,
    output logic                             pready
);
    import bbs_pkg::*;

    localparam int WID_W = $clog2(MAX_WIDTH + 1);
    localparam int HGT_W = $clog2(MAX_HEIGHT + 1);

    logic [WID_W-1:0]  w_eff;
    logic [HGT_W-1:0]  h_eff;
    logic              restart;
    logic              acc;
    win_t              win;
    meta_t             meta;
    ls_stat_t          stat;
    logic              mean_valid;
    res_t              mean_res;
    res_t              out_res;
    logic [OUT_CW-1:0] fifo_count;
    logic [OUT_CW-1:0] occ;

    // Queue slots claimed by results in flight or waiting
    assign occ = fifo_count + OUT_CW'(stat.v1 && stat.e1) + OUT_CW'(stat.v2)
               + OUT_CW'(mean_valid);
    assign pixels.ready = (occ < OUT_CW'(OUT_DEPTH));
    assign acc          = pixels.valid && pixels.ready;

    bbs_cfg_regs #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .w_eff   (w_eff),
        .h_eff   (h_eff),
        .restart (restart)
    );

    bbs_line_store #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_line (
        .clk     (clk),
        .rst_n   (rst_n),
        .restart (restart),
        .acc     (acc),
        .px      (pixels.pixel_in),
        .w_eff   (w_eff),
        .h_eff   (h_eff),
        .win     (win),
        .meta    (meta),
        .stat    (stat)
    );

    bbs_mean u_mean (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (stat.v2),
        .win       (win),
        .meta      (meta),
        .out_valid (mean_valid),
        .res       (mean_res)
    );

    bbs_out_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (mean_valid),
        .wr_data  (mean_res),
        .rd_valid (results.valid),
        .rd_ready (results.ready),
        .rd_data  (out_res),
        .count    (fifo_count)
    );

    assign results.pixel_out  = out_res.pixel;
    assign results.out_row    = out_res.row;
    assign results.out_col    = out_res.col;
    assign results.frame_last = out_res.last;

    // Queue credit never overcommitted
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ <= OUT_CW'(OUT_DEPTH))
        else $error("result queue overcommitted");

    // Accepted pixel enters the memory read stage
    a_acc_stage: assert property (@(posedge clk) disable iff (!rst_n)
        acc && !restart |=> stat.v1)
        else $error("accepted pixel lost before line store");

    // A result window always reaches the mean stage
    a_mean_follow: assert property (@(posedge clk) disable iff (!rst_n)
        stat.v2 |=> mean_valid)
        else $error("result window dropped");

endmodule

`default_nettype wire

>>> rtl/core/bbs_cfg_regs.sv
// APB register block: image width and height, clamped frame size, restart strobe.
// Depends on bbs_pkg.
`default_nettype none

module bbs_cfg_regs #(
    parameter int MAX_WIDTH  = bbs_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = bbs_pkg::MAX_HEIGHT_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [bbs_pkg::CFG_AW-1:0]      paddr,
    input  wire logic [bbs_pkg::APB_DW-1:0]      pwdata,
    output logic      [bbs_pkg::APB_DW-1:0]      prdata,
    output logic                                 pready,
    output logic      [$clog2(MAX_WIDTH+1)-1:0]  w_eff,
    output logic      [$clog2(MAX_HEIGHT+1)-1:0] h_eff,
    output logic                                 restart
);
    import bbs_pkg::*;

    localparam int WID_W = $clog2(MAX_WIDTH + 1);
    localparam int HGT_W = $clog2(MAX_HEIGHT + 1);
    localparam int DW_W  = (WID_W > CFG_W) ? WID_W : CFG_W;
    localparam int DH_W  = (HGT_W > CFG_W) ? HGT_W : CFG_W;

    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    logic             wr_en;
    cfg_reg_t         sel;
    logic [DW_W-1:0]  w_ext;
    logic [DH_W-1:0]  h_ext;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign sel     = cfg_reg_t'(paddr[2]);
    assign restart = wr_en;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= CFG_W'(WIDTH_RST);
            height_reg <= CFG_W'(HEIGHT_RST);
        end
        else if (wr_en)
        begin
            unique case (sel)
                REG_WIDTH:  width_reg  <= pwdata[CFG_W-1:0];
                REG_HEIGHT: height_reg <= pwdata[CFG_W-1:0];
                default:    ;
            endcase
        end
    end

    // Read back
    always_comb
    begin
        unique case (sel)
            REG_WIDTH:  prdata = APB_DW'(width_reg);
            REG_HEIGHT: prdata = APB_DW'(height_reg);
            default:    prdata = '0;
        endcase
    end

    // Clamp sizes into 3..MAX
    assign w_ext = DW_W'(width_reg);
    assign h_ext = DH_W'(height_reg);

    always_comb
    begin
        if (w_ext < DW_W'(MIN_DIM))
            w_eff = WID_W'(MIN_DIM);
        else if (w_ext > DW_W'(MAX_WIDTH))
            w_eff = WID_W'(MAX_WIDTH);
        else
            w_eff = WID_W'(w_ext);

        if (h_ext < DH_W'(MIN_DIM))
            h_eff = HGT_W'(MIN_DIM);
        else if (h_ext > DH_W'(MAX_HEIGHT))
            h_eff = HGT_W'(MAX_HEIGHT);
        else
            h_eff = HGT_W'(h_ext);
    end

endmodule

`default_nettype wire

>>> rtl/core/bbs_line_store.sv
// Line store memory with read-modify-write, raster counters and the 3x3 window.
// Depends on bbs_pkg.
`default_nettype none

module bbs_line_store #(
    parameter int MAX_WIDTH  = bbs_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = bbs_pkg::MAX_HEIGHT_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 restart,
    input  wire logic                                 acc,
    input  wire logic      [bbs_pkg::PIX_W-1:0]       px,
    input  wire logic      [$clog2(MAX_WIDTH+1)-1:0]  w_eff,
    input  wire logic      [$clog2(MAX_HEIGHT+1)-1:0] h_eff,
    output bbs_pkg::win_t                             win,
    output bbs_pkg::meta_t                            meta,
    output bbs_pkg::ls_stat_t                         stat
);
    import bbs_pkg::*;

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int WID_W = $clog2(MAX_WIDTH + 1);
    localparam int HGT_W = $clog2(MAX_HEIGHT + 1);

    // Each word holds {row before previous, previous row} for one column
    logic [2*PIX_W-1:0] mem [MAX_WIDTH];
    logic [2*PIX_W-1:0] rd_reg;

    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic             v1_reg, e1_reg, v2_reg;
    win_t             win_reg, win_next;
    logic [PIX_W-1:0] px1_reg;
    logic [COL_W-1:0] addr1_reg;
    meta_t            meta1_reg, meta2_reg;
    meta_t            meta_in;
    logic             col_end, row_end, emit;

    // Position of the arriving pixel
    assign col_end = (WID_W'(col_reg) == w_eff - WID_W'(1));
    assign row_end = (HGT_W'(row_reg) == h_eff - HGT_W'(1));
    assign emit    = (row_reg >= ROW_W'(2)) && (col_reg >= COL_W'(2));

    assign meta_in.row  = COORD_W'(row_reg - ROW_W'(1));
    assign meta_in.col  = COORD_W'(col_reg - COL_W'(1));
    assign meta_in.last = col_end && row_end;

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (acc)
        begin
            if (col_end)
            begin
                col_next = '0;
                row_next = row_end ? '0 : row_reg + ROW_W'(1);
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    // Window shift: new column is {row before previous, previous row, pixel}
    always_comb
    begin
        win_next = win_reg;
        if (v1_reg)
        begin
            for (int i = 0; i < 3; i++)
            begin
                win_next[i*3]     = win_reg[i*3+1];
                win_next[i*3 + 1] = win_reg[i*3+2];
            end
            win_next[2] = rd_reg[2*PIX_W-1:PIX_W];
            win_next[5] = rd_reg[PIX_W-1:0];
            win_next[8] = px1_reg;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
            v1_reg  <= 1'b0;
            e1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            win_reg <= '0;
        end
        else if (restart)
        begin
            col_reg <= '0;
            row_reg <= '0;
            v1_reg  <= 1'b0;
            e1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            win_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
            v1_reg  <= acc;
            e1_reg  <= acc && emit;
            v2_reg  <= v1_reg && e1_reg;
            win_reg <= win_next;
        end
    end

    // Stage payload
    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            px1_reg   <= px;
            addr1_reg <= col_reg;
            meta1_reg <= meta_in;
        end
        if (v1_reg)
            meta2_reg <= meta1_reg;
    end

    // Memory: read at accept, write back in the next cycle. The same column
    // comes round again only after at least three items, so a read never
    // meets a pending write to its entry.
    always_ff @(posedge clk)
    begin
        if (acc)
            rd_reg <= mem[col_reg];
        if (v1_reg)
            mem[addr1_reg] <= {rd_reg[PIX_W-1:0], px1_reg};
    end

    assign win     = win_reg;
    assign meta    = meta2_reg;
    assign stat.v1 = v1_reg;
    assign stat.e1 = e1_reg;
    assign stat.v2 = v2_reg;

endmodule

`default_nettype wire

>>> rtl/core/bbs_mean.sv
// Window mean: registered sum of nine pixels, then multiply by reciprocal of nine.
// Depends on bbs_pkg.
`default_nettype none

module bbs_mean (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    input  wire bbs_pkg::win_t  win,
    input  wire bbs_pkg::meta_t meta,
    output logic                out_valid,
    output bbs_pkg::res_t       res
);
    import bbs_pkg::*;

    logic [SUM_W-1:0]  sum;
    logic [SUM_W-1:0]  sum_reg;
    meta_t             meta_reg;
    logic              v3_reg;
    logic [PROD_W-1:0] prod;

    // Nine-pixel sum
    always_comb
    begin
        sum = '0;
        for (int i = 0; i < 9; i++)
            sum = sum + SUM_W'(win[i]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else
            v3_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            sum_reg  <= sum;
            meta_reg <= meta;
        end
    end

    // floor(sum / 9)
    assign prod = PROD_W'(sum_reg) * PROD_W'(DIV9_MUL);

    assign out_valid = v3_reg;
    assign res.pixel = prod[DIV9_SHIFT +: PIX_W];
    assign res.row   = meta_reg.row;
    assign res.col   = meta_reg.col;
    assign res.last  = meta_reg.last;

endmodule

`default_nettype wire

>>> rtl/core/bbs_out_fifo.sv
// Result queue that decouples the fixed-latency pipeline from output stalls.
// Depends on bbs_pkg.
`default_nettype none

module bbs_out_fifo (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         wr_en,
    input  wire bbs_pkg::res_t                wr_data,
    output logic                              rd_valid,
    input  wire logic                         rd_ready,
    output bbs_pkg::res_t                     rd_data,
    output logic      [bbs_pkg::OUT_CW-1:0]   count
);
    import bbs_pkg::*;

    res_t              fifo_mem [OUT_DEPTH];
    logic [OUT_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [OUT_CW-1:0] count_reg;
    logic              rd_en;

    assign rd_valid = (count_reg != '0);
    assign rd_en    = rd_valid && rd_ready;
    assign rd_data  = fifo_mem[rd_ptr_reg];
    assign count    = count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
                wr_ptr_reg <= wr_ptr_reg + OUT_AW'(1);
            if (rd_en)
                rd_ptr_reg <= rd_ptr_reg + OUT_AW'(1);
            case ({wr_en, rd_en})
                2'b10:   count_reg <= count_reg + OUT_CW'(1);
                2'b01:   count_reg <= count_reg - OUT_CW'(1);
                default: count_reg <= count_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            fifo_mem[wr_ptr_reg] <= wr_data;
    end

endmodule

`default_nettype wire

>>> tb/box_blur_3x3_stream_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for box_blur_3x3_stream: directed table, then random frames.
// Depends on bbs_pkg, bbs_if and the box_blur_3x3_stream RTL.

module box_blur_3x3_stream_tb;
    import bbs_pkg::*;

    localparam int WINDOW_TAPS    = 9;
    localparam int PAUSE_CYCLES   = 8;      // pipeline plus queue drain margin
    localparam int STALL_CYCLES   = 300;    // long receiver hold-off
    localparam int ITEMS_PER_MODE = 220;
    localparam int FILL_W         = 12;     // frame streamed against the long hold-off
    localparam int FILL_H         = 8;

    typedef enum
    {
        STEP_READ,
        STEP_WRITE,
        STEP_PIXEL
    } step_kind_t;

    typedef struct
    {
        step_kind_t       kind;
        cfg_reg_t         which;
        logic [CFG_W-1:0] value;
        logic [PIX_W-1:0] pixel;
        bit               typed;
        res_t             want;
    } step_t;

    logic                clk     = 1'b0;
    logic                rst_n   = 1'b0;
    logic                psel    = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite  = 1'b0;
    logic [CFG_AW-1:0]   paddr   = '0;
    logic [APB_DW-1:0]   pwdata  = '0;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    bbs_pix_if pix_ch ();
    bbs_res_if res_ch ();

    box_blur_3x3_stream DUT
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .pixels  (pix_ch),
        .results (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Predictor state: size registers, line stores, window, raster position
    logic [CFG_W-1:0] size_w;
    logic [CFG_W-1:0] size_h;
    logic [PIX_W-1:0] prev_row  [MAX_WIDTH_DEF];
    logic [PIX_W-1:0] older_row [MAX_WIDTH_DEF];
    logic [PIX_W-1:0] win       [WINDOW_TAPS];
    int unsigned      cur_row;
    int unsigned      cur_col;

    res_t blur_expect [$];
    int   err_count    = 0;
    int   pixels_sent  = 0;
    int   snd_idle_pct = 0;
    int   rcv_idle_pct = 0;
    logic rx_hold      = 1'b0;

    always #5 clk = ~clk;

    // Run limit
    initial
    begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic int clamp_dim(logic [CFG_W-1:0] v, int hi);
        if (v < MIN_DIM)
            return MIN_DIM;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic void restart_frame();
        foreach (win[i])
            win[i] = '0;
        cur_row = 0;
        cur_col = 0;
    endfunction

    // One pixel through the predictor; returns 1 when an interior result is due
    function automatic bit blur_step(input logic [PIX_W-1:0] px, output res_t r);
        int          w;
        int          h;
        int          sum;
        int unsigned rr;
        int unsigned cc;
        bit          made;

        w    = clamp_dim(size_w, MAX_WIDTH_DEF);
        h    = clamp_dim(size_h, MAX_HEIGHT_DEF);
        made = 1'b0;
        r    = '0;
        if (cur_col >= w)
            cur_col = 0;
        if (cur_row >= h)
            cur_row = 0;
        rr = cur_row;
        cc = cur_col;

        // shift window left, new column from line stores and input
        for (int i = 0; i < 3; i++)
        begin
            win[i*3]   = win[i*3+1];
            win[i*3+1] = win[i*3+2];
        end
        win[2] = older_row[cc];
        win[5] = prev_row[cc];
        win[8] = px;
        older_row[cc] = prev_row[cc];
        prev_row[cc]  = px;

        if (rr >= 2 && cc >= 2)
        begin
            sum = 0;
            foreach (win[i])
                sum += win[i];
            r.pixel = PIX_W'(sum / WINDOW_TAPS);
            r.row   = COORD_W'(rr - 1);
            r.col   = COORD_W'(cc - 1);
            r.last  = (rr == h - 1) && (cc == w - 1);
            made    = 1'b1;
        end

        cur_col = cc + 1;
        if (cur_col >= w)
        begin
            cur_col = 0;
            cur_row = rr + 1;
            if (cur_row >= h)
                cur_row = 0;
        end
        return made;
    endfunction

    task automatic flag_error(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        err_count++;
    endtask

    // APB write: setup then access; register loads at the access edge
    task automatic apb_write(input cfg_reg_t which, input logic [APB_DW-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {which, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Write a size register with junk above bit 11, mirror it in the predictor
    task automatic write_size(input cfg_reg_t which, input logic [CFG_W-1:0] value);
        apb_write(which, {(APB_DW-CFG_W)'($urandom()), value});
        if (which == REG_WIDTH)
            size_w = value;
        else
            size_h = value;
        restart_frame();
    endtask

    task automatic read_size(input cfg_reg_t which, input logic [CFG_W-1:0] want);
        logic [APB_DW-1:0] got;

        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {which, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        @(negedge clk);
        got = prdata;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got !== APB_DW'(want))
            flag_error($sformatf("%s reads %0d, want %0d", which.name(), got, want));
    endtask

    // Drop valid, let every expected item come out, then let the pipeline settle
    task automatic wait_idle();
        pix_ch.valid <= 1'b0;
        while (blur_expect.size() != 0)
            @(posedge clk);
        repeat (PAUSE_CYCLES) @(posedge clk);
    endtask

    // Offer one pixel, wait for the handshake, log what the block owes for it
    task automatic send_pixel(input logic [PIX_W-1:0] px, input bit typed, input res_t want);
        res_t guess;
        bit   made;

        while ($urandom_range(0, 99) < snd_idle_pct)
        begin
            pix_ch.valid <= 1'b0;
            @(posedge clk);
        end
        pix_ch.valid    <= 1'b1;
        pix_ch.pixel_in <= px;
        @(posedge clk);
        while (!pix_ch.ready)
            @(posedge clk);
        made = blur_step(px, guess);
        if (typed)
            blur_expect.push_back(want);
        else if (made)
            blur_expect.push_back(guess);
        pixels_sent++;
    endtask

    task automatic stream_random(input int count);
        logic [PIX_W-1:0] px;

        repeat (count)
        begin
            // some saturated values among plain noise
            if ($urandom_range(0, 9) == 0)
                px = $urandom_range(0, 1) ? {PIX_W{1'b1}} : '0;
            else
                px = PIX_W'($urandom());
            send_pixel(px, 1'b0, '0);
        end
    endtask

    function automatic int pick_dim(input int common_hi, input int rare_hi);
        int roll;

        roll = $urandom_range(0, 99);
        if (roll < 10)
            return $urandom_range(0, MIN_DIM - 1);
        if (roll < 20)
            return $urandom_range(common_hi + 1, rare_hi);
        return $urandom_range(MIN_DIM, common_hi);
    endfunction

    // Random sizes; mostly whole frames, some cut short by the next write
    task automatic random_frames(input int items);
        int start;
        int w;
        int h;
        int chunk;

        start = pixels_sent;
        while (pixels_sent - start < items)
        begin
            wait_idle();
            case ($urandom_range(0, 3))
                0: write_size(REG_WIDTH, CFG_W'(pick_dim(12, 40)));
                1: write_size(REG_HEIGHT, CFG_W'(pick_dim(8, 16)));
                default:
                begin
                    write_size(REG_WIDTH, CFG_W'(pick_dim(12, 40)));
                    write_size(REG_HEIGHT, CFG_W'(pick_dim(8, 16)));
                end
            endcase
            if ($urandom_range(0, 3) == 0)
                read_size(REG_WIDTH, size_w);
            w = clamp_dim(size_w, MAX_WIDTH_DEF);
            h = clamp_dim(size_h, MAX_HEIGHT_DEF);
            if ($urandom_range(0, 3) != 0)
                chunk = w * h * int'($urandom_range(1, 2));
            else
                chunk = int'($urandom_range(1, w * h + w));
            // keep the item budget of this mode
            if (chunk > items - (pixels_sent - start))
                chunk = items - (pixels_sent - start);
            stream_random(chunk);
        end
        wait_idle();
    endtask

    // Long receiver hold-off, own process
    task automatic hold_results();
        rx_hold <= 1'b1;
        repeat (STALL_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
    endtask

    // Receiver side ready
    always @(posedge clk)
        res_ch.ready <= !rx_hold && ($urandom_range(0, 99) >= rcv_idle_pct);

    // Result checker
    always @(posedge clk)
    begin
        if (rst_n && res_ch.valid && res_ch.ready)
        begin : check_item
            res_t want;

            if (blur_expect.size() == 0)
                flag_error($sformatf("unexpected item at (%0d,%0d)",
                                     res_ch.out_row, res_ch.out_col));
            else
            begin
                want = blur_expect.pop_front();
                if (res_ch.pixel_out !== want.pixel)
                    flag_error($sformatf("pixel_out %0d, want %0d at (%0d,%0d)",
                                         res_ch.pixel_out, want.pixel, want.row, want.col));
                if (res_ch.out_row !== want.row)
                    flag_error($sformatf("out_row %0d, want %0d", res_ch.out_row, want.row));
                if (res_ch.out_col !== want.col)
                    flag_error($sformatf("out_col %0d, want %0d", res_ch.out_col, want.col));
                if (res_ch.frame_last !== want.last)
                    flag_error($sformatf("frame_last %0b, want %0b at (%0d,%0d)",
                                         res_ch.frame_last, want.last, want.row, want.col));
            end
        end
    end

    function automatic step_t reg_read(input cfg_reg_t which, input int value);
        step_t s;

        s       = '{default: '0, kind: STEP_READ, which: REG_WIDTH, want: '0};
        s.which = which;
        s.value = CFG_W'(value);
        return s;
    endfunction

    function automatic step_t reg_write(input cfg_reg_t which, input int value);
        step_t s;

        s      = reg_read(which, value);
        s.kind = STEP_WRITE;
        return s;
    endfunction

    function automatic step_t pixel_item(input logic [PIX_W-1:0] px);
        step_t s;

        s       = reg_read(REG_WIDTH, 0);
        s.kind  = STEP_PIXEL;
        s.pixel = px;
        return s;
    endfunction

    function automatic step_t pixel_checked(input logic [PIX_W-1:0] px, input int mean,
                                            input int row, input int col, input bit last);
        step_t s;

        s            = pixel_item(px);
        s.typed      = 1'b1;
        s.want.pixel = PIX_W'(mean);
        s.want.row   = COORD_W'(row);
        s.want.col   = COORD_W'(col);
        s.want.last  = last;
        return s;
    endfunction

    // Main sequence
    initial
    begin
        step_t steps [$];

        pix_ch.valid    = 1'b0;
        pix_ch.pixel_in = '0;
        res_ch.ready    = 1'b0;
        size_w          = CFG_W'(WIDTH_RST);
        size_h          = CFG_W'(HEIGHT_RST);
        foreach (prev_row[i])
        begin
            prev_row[i]  = '0;
            older_row[i] = '0;
        end
        restart_frame();
        snd_idle_pct = 9;
        rcv_idle_pct = 45;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table: reset values, smallest frame, flat extremes,
        // floor of the mean, clamping of out-of-range sizes
        steps.push_back(reg_read(REG_WIDTH, WIDTH_RST));
        steps.push_back(reg_read(REG_HEIGHT, HEIGHT_RST));
        steps.push_back(reg_write(REG_WIDTH, MIN_DIM));
        steps.push_back(reg_write(REG_HEIGHT, MIN_DIM));
        repeat (8) steps.push_back(pixel_item(8'hFF));
        steps.push_back(pixel_checked(8'hFF, 255, 1, 1, 1'b1));
        repeat (8) steps.push_back(pixel_item(8'd10));
        steps.push_back(pixel_checked(8'd0, 8, 1, 1, 1'b1));
        steps.push_back(reg_write(REG_WIDTH, 1));
        steps.push_back(reg_write(REG_HEIGHT, 4095));
        steps.push_back(reg_read(REG_WIDTH, 1));
        steps.push_back(reg_read(REG_HEIGHT, 4095));
        for (int b = 0; b < PIX_W; b++)
            steps.push_back(pixel_item(PIX_W'(1 << b)));
        steps.push_back(pixel_checked(8'd0, 28, 1, 1, 1'b0));

        foreach (steps[i])
        begin
            case (steps[i].kind)
                STEP_READ:
                begin
                    wait_idle();
                    read_size(steps[i].which, steps[i].value);
                end
                STEP_WRITE:
                begin
                    wait_idle();
                    write_size(steps[i].which, steps[i].value);
                end
                default:
                    send_pixel(steps[i].pixel, steps[i].typed, steps[i].want);
            endcase
        end

        // Random frames, sender mostly busy, receiver stalls often
        random_frames(ITEMS_PER_MODE);

        // Roles swapped
        snd_idle_pct = 45;
        rcv_idle_pct = 9;
        random_frames(ITEMS_PER_MODE);

        // Full rate, with one long output stall over a whole frame to back up the input
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        write_size(REG_WIDTH, CFG_W'(FILL_W));
        write_size(REG_HEIGHT, CFG_W'(FILL_H));
        fork
            hold_results();
        join_none
        stream_random(FILL_W * FILL_H);
        random_frames(ITEMS_PER_MODE - FILL_W * FILL_H);

        if (blur_expect.size() != 0)
            flag_error($sformatf("%0d items never came out", blur_expect.size()));
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

>>> files.f
rtl/core/bbs_pkg.sv
rtl/core/bbs_if.sv
rtl/core/bbs_cfg_regs.sv
rtl/core/bbs_line_store.sv
rtl/core/bbs_mean.sv
rtl/core/bbs_out_fifo.sv
rtl/core/box_blur_3x3_stream.sv
tb/box_blur_3x3_stream_tb.sv
